// ===== rtl/core/sha_pkg.sv =====
`default_nettype none

package sha_pkg;

    localparam int WORD_W       = 32;
    localparam int BYTE_W       = 8;
    localparam int COUNT_W      = 61;
    localparam int NUM_ROUNDS   = 64;
    localparam int BLOCK_WORDS  = 16;
    localparam int DIGEST_WORDS = 8;
    localparam int LEN_LIMIT    = 56;

    typedef logic [WORD_W-1:0] t_word;

    localparam logic [2:0]        LAST_INDEX = 3'(DIGEST_WORDS - 1);
    localparam logic [BYTE_W-1:0] PAD_BYTE   = 8'h80;

    // One input word: a message byte and its flags.
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              byte_valid;
        logic              end_of_message;
    } t_in;

    // One output word: a digest word, its position and the final flag.
    typedef struct packed {
        t_word      digest_word;
        logic [2:0] word_index;
        logic       last_word;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_PAD2,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        BLK_DATA,
        BLK_PAD_MORE,
        BLK_FINAL
    } t_blk;

    localparam t_word IV_TAB [DIGEST_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word K_TAB [NUM_ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic t_word choose(input t_word e, input t_word f, input t_word g);
        return (e & f) ^ (~e & g);
    endfunction

    function automatic t_word majority(input t_word a, input t_word b, input t_word c);
        return (a & b) ^ (a & c) ^ (b & c);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/sha256_stream_hasher.sv =====
// SHA-256 hasher that takes a message one byte per input word.
// Input channel (i_valid/o_ready, payload i_data): each word carries a
// message byte with byte_valid, and end_of_message on the last word. An end
// word with byte_valid low finishes the message without a byte, so an empty
// message hashes too. Output channel (o_valid/i_ready, payload o_data): after
// an end word the block delivers eight digest words, h0 first, the last one
// flagged with last_word.
// Timing: a plain byte only fills the buffer. The byte that fills the
// 64-byte buffer starts a compression: the single round unit runs one round
// per cycle for 64 rounds and then folds the result into the chaining
// value. After an end word the first digest word appears after one
// compression, or after two when the end word fills the buffer or the
// padding spills into a second block, and then one word per cycle while
// the receiver takes them.
// The block takes one message word at a time and holds o_ready low while
// compressing or delivering the digest. When the receiver stalls, the
// current digest word holds on o_data. After the last digest word the block
// returns to the initial hash values with an empty buffer, as after reset.
// Synchronous reset clears the sequencer and counters, sets initial hash values.
`default_nettype none

module sha256_stream_hasher (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sha_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output sha_pkg::t_out o_data
);
    import sha_pkg::*;

    t_state r_state, n_state;
    t_blk   r_blk;
    logic   r_eom_pend;

    logic [5:0]         r_fill;
    logic [COUNT_W-1:0] r_count;
    logic [5:0]         r_round;
    logic [2:0]         r_oidx;

    // Chaining value, working variables and the 16-word schedule window.
    // The window holds the block bytes while they arrive and then slides
    // one word per round during compression.
    t_word r_h [DIGEST_WORDS];
    t_word r_v [DIGEST_WORDS];
    t_word r_w [BLOCK_WORDS];

    logic        in_acc;
    logic        out_acc;
    logic        buf_full;
    logic [63:0] bit_len;
    logic [5:0]  pad_pos;
    logic [1:0]  lane_inv;
    t_word       pad_words [BLOCK_WORDS];
    t_word       t1_sum;
    t_word       t2_sum;
    t_word       w_next;

    assign in_acc   = i_valid && o_ready;
    assign out_acc  = o_valid && i_ready;
    assign buf_full = i_data.byte_valid && (r_fill == 6'd63);
    assign bit_len  = {r_count, 3'b000};
    assign lane_inv = ~r_fill[1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (buf_full) begin
                        n_state = ST_ROUND;
                    end else if (i_data.end_of_message) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD:   n_state = ST_ROUND;
            ST_PAD2:  n_state = ST_ROUND;
            ST_ROUND: begin
                if (r_round == 6'(NUM_ROUNDS - 1)) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                unique case (r_blk)
                    BLK_DATA:     n_state = r_eom_pend ? ST_PAD : ST_IDLE;
                    BLK_PAD_MORE: n_state = ST_PAD2;
                    BLK_FINAL:    n_state = ST_OUT;
                    default:      n_state = ST_IDLE;
                endcase
            end
            ST_OUT: begin
                if (out_acc && (r_oidx == LAST_INDEX)) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Handshake and result outputs.
    always_comb begin
        o_ready            = (r_state == ST_IDLE);
        o_valid            = (r_state == ST_OUT);
        o_data.digest_word = r_h[r_oidx];
        o_data.word_index  = r_oidx;
        o_data.last_word   = (r_oidx == LAST_INDEX);
    end

    // Padded block: bytes before the fill position are kept, the byte at the
    // fill position becomes the marker byte and everything after it is zero.
    always_comb begin
        pad_pos = '0;
        for (int j = 0; j < BLOCK_WORDS; j++) begin
            for (int b = 0; b < 4; b++) begin
                pad_pos = 6'(4 * j + b);
                if (pad_pos < r_fill) begin
                    pad_words[j][8*(3-b) +: 8] = r_w[j][8*(3-b) +: 8];
                end else if (pad_pos == r_fill) begin
                    pad_words[j][8*(3-b) +: 8] = PAD_BYTE;
                end else begin
                    pad_words[j][8*(3-b) +: 8] = '0;
                end
            end
        end
    end

    // One compression round and one schedule step.
    always_comb begin
        t1_sum = r_v[7] + big_sigma1(r_v[4]) + choose(r_v[4], r_v[5], r_v[6])
                 + K_TAB[r_round] + r_w[0];
        t2_sum = big_sigma0(r_v[0]) + majority(r_v[0], r_v[1], r_v[2]);
        w_next = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];
    end

    // Control state, counters and chaining value.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_blk      <= BLK_DATA;
            r_eom_pend <= 1'b0;
            r_fill     <= '0;
            r_count    <= '0;
            r_round    <= '0;
            r_oidx     <= '0;
            for (int i = 0; i < DIGEST_WORDS; i++) begin
                r_h[i] <= IV_TAB[i];
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (i_data.byte_valid) begin
                            r_fill  <= r_fill + 6'd1;
                            r_count <= r_count + COUNT_W'(1);
                        end
                        r_blk      <= BLK_DATA;
                        r_eom_pend <= i_data.end_of_message;
                        r_round    <= '0;
                    end
                end
                ST_PAD: begin
                    r_blk   <= (r_fill >= 6'(LEN_LIMIT)) ? BLK_PAD_MORE : BLK_FINAL;
                    r_round <= '0;
                end
                ST_PAD2: begin
                    r_blk   <= BLK_FINAL;
                    r_round <= '0;
                end
                ST_ROUND: begin
                    r_round <= r_round + 6'd1;
                end
                ST_ADD: begin
                    for (int i = 0; i < DIGEST_WORDS; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                end
                ST_OUT: begin
                    if (out_acc) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == LAST_INDEX) begin
                            r_fill  <= '0;
                            r_count <= '0;
                            for (int i = 0; i < DIGEST_WORDS; i++) begin
                                r_h[i] <= IV_TAB[i];
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Block buffer, schedule window and working variables.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc && i_data.byte_valid) begin
                    r_w[r_fill[5:2]][{lane_inv, 3'b000} +: 8] <= i_data.data_byte;
                end
                for (int i = 0; i < DIGEST_WORDS; i++) begin
                    r_v[i] <= r_h[i];
                end
            end
            ST_PAD: begin
                for (int j = 0; j < BLOCK_WORDS - 2; j++) begin
                    r_w[j] <= pad_words[j];
                end
                if (r_fill < 6'(LEN_LIMIT)) begin
                    r_w[BLOCK_WORDS-2] <= bit_len[63:32];
                    r_w[BLOCK_WORDS-1] <= bit_len[31:0];
                end else begin
                    r_w[BLOCK_WORDS-2] <= pad_words[BLOCK_WORDS-2];
                    r_w[BLOCK_WORDS-1] <= pad_words[BLOCK_WORDS-1];
                end
                for (int i = 0; i < DIGEST_WORDS; i++) begin
                    r_v[i] <= r_h[i];
                end
            end
            ST_PAD2: begin
                for (int j = 0; j < BLOCK_WORDS - 2; j++) begin
                    r_w[j] <= '0;
                end
                r_w[BLOCK_WORDS-2] <= bit_len[63:32];
                r_w[BLOCK_WORDS-1] <= bit_len[31:0];
                for (int i = 0; i < DIGEST_WORDS; i++) begin
                    r_v[i] <= r_h[i];
                end
            end
            ST_ROUND: begin
                for (int j = 0; j < BLOCK_WORDS - 1; j++) begin
                    r_w[j] <= r_w[j+1];
                end
                r_w[BLOCK_WORDS-1] <= w_next;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1_sum;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= t1_sum + t2_sum;
            end
            ST_ADD: ;
            ST_OUT: ;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/sha_chk.sv =====
`default_nettype none

module sha_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input sha_pkg::t_in  i_data,
    input logic          o_valid,
    input logic          i_ready,
    input sha_pkg::t_out o_data
);
    import sha_pkg::*;

    // The block never takes a message word while a digest is pending.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input ready while digest words are pending");

    // An end word starts the finish, so the input closes right after it.
    a_eom_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_data.end_of_message) |=> !o_ready)
        else $error("input still ready after an end word");

    // Digest words come out in order without gaps.
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_data.last_word) |=>
            (o_valid && (o_data.word_index == 3'($past(o_data.word_index) + 3'd1))))
        else $error("digest word index did not advance by one");

    // After the final digest word the block is ready for a new message.
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_data.last_word && (o_data.word_index == LAST_INDEX))
            |=> (!o_valid && o_ready))
        else $error("block not back to idle after the final digest word");

    // A stalled digest word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("digest word changed while stalled");

endmodule

bind sha256_stream_hasher sha_chk u_sha_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .i_data  (i_data),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_data  (o_data)
);

`default_nettype wire

// ===== dv/sha256_stream_hasher_tb.sv =====
`timescale 1ns / 100ps

module sha256_stream_hasher_tb;

    // Timing of the run. The hold-off is far longer than one message takes,
    // so the block ends up with a finished digest and no way to hand it off.
    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_BURST     = 17;

    // Constants of the hash itself, kept here so that the prediction does not
    // lean on the tables that the design uses.
    localparam int          DIGEST_LEN = 8;
    localparam int          BLOCK_LEN  = 64;
    localparam int          LEN_FIELD  = 56;
    localparam logic [7:0]  PAD_MARK   = 8'h80;

    localparam logic [31:0] H_START [DIGEST_LEN] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_CONST [BLOCK_LEN] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    // Everything the block sees is a register of this testbench, so every
    // input is known from time zero.
    logic           clk      = 1'b0;
    logic           rst_n    = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_ready = 1'b0;
    sha_pkg::t_in   in_data  = '0;
    logic           out_ready;
    logic           out_valid;
    sha_pkg::t_out  out_data;

    // Knobs shared by the tests and the two handshake sides. They only change
    // through nonblocking assignments at a clock edge.
    logic           tx_idle_en = 1'b1;
    logic           rx_idle_en = 1'b1;
    logic           rx_hold    = 1'b0;

    int             err_cnt   = 0;
    int             cycle_cnt = 0;
    int             rx_stall_left = 0;

    // Predicted hash state and the digest words still owed by the block.
    logic [31:0]    hv_model [DIGEST_LEN];
    logic [7:0]     blk_model [BLOCK_LEN];
    logic [6:0]     fill_model;
    logic [60:0]    len_model;
    sha_pkg::t_out  digest_q [$];

    sha256_stream_hasher i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (out_ready),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_ready (in_ready),
        .o_data  (out_data)
    );

    always begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // The run is cut off if the design hangs somewhere.
    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] rot_right(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // One compression of the 64-byte buffer into the chaining value.
    task automatic sha_compress();
        logic [31:0] w [BLOCK_LEN];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2, s0, s1;
        int          i;
        for (i = 0; i < 16; i++) begin
            w[i] = {blk_model[4*i], blk_model[4*i+1], blk_model[4*i+2], blk_model[4*i+3]};
        end
        for (i = 16; i < BLOCK_LEN; i++) begin
            s0 = rot_right(w[i-15], 7) ^ rot_right(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rot_right(w[i-2], 17) ^ rot_right(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        a = hv_model[0]; b = hv_model[1]; c = hv_model[2]; d = hv_model[3];
        e = hv_model[4]; f = hv_model[5]; g = hv_model[6]; h = hv_model[7];
        for (i = 0; i < BLOCK_LEN; i++) begin
            t1 = h + (rot_right(e, 6) ^ rot_right(e, 11) ^ rot_right(e, 25)) +
                 ((e & f) ^ (~e & g)) + ROUND_CONST[i] + w[i];
            t2 = (rot_right(a, 2) ^ rot_right(a, 13) ^ rot_right(a, 22)) +
                 ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hv_model[0] += a; hv_model[1] += b; hv_model[2] += c; hv_model[3] += d;
        hv_model[4] += e; hv_model[5] += f; hv_model[6] += g; hv_model[7] += h;
    endtask

    task automatic sha_restart();
        int i;
        for (i = 0; i < DIGEST_LEN; i++) hv_model[i] = H_START[i];
        for (i = 0; i < BLOCK_LEN; i++) blk_model[i] = '0;
        fill_model = '0;
        len_model  = '0;
    endtask

    // Folds one accepted input word into the predicted state. An end word
    // pads the message, runs the last one or two blocks and queues the eight
    // digest words the block owes.
    task automatic sha_absorb(input sha_pkg::t_in w);
        logic [63:0]   bit_len;
        sha_pkg::t_out dw;
        int            i;
        if (w.byte_valid) begin
            blk_model[fill_model[5:0]] = w.data_byte;
            fill_model = fill_model + 7'd1;
            len_model  = len_model + 61'd1;
            if (fill_model >= 7'(BLOCK_LEN)) begin
                sha_compress();
                fill_model = '0;
            end
        end
        if (!w.end_of_message) return;

        // The pad marker always fits; the length field may need a fresh block.
        blk_model[fill_model[5:0]] = PAD_MARK;
        for (i = int'(fill_model) + 1; i < BLOCK_LEN; i++) blk_model[i] = '0;
        if (fill_model >= 7'(LEN_FIELD)) begin
            sha_compress();
            for (i = 0; i < BLOCK_LEN; i++) blk_model[i] = '0;
        end
        bit_len = {len_model, 3'b000};
        for (i = 0; i < 8; i++) blk_model[BLOCK_LEN-1-i] = bit_len[8*i +: 8];
        sha_compress();

        for (i = 0; i < DIGEST_LEN; i++) begin
            dw.digest_word = hv_model[i];
            dw.word_index  = 3'(i);
            dw.last_word   = (i == DIGEST_LEN - 1);
            digest_q.push_back(dw);
        end
        sha_restart();
    endtask

    function automatic sha_pkg::t_in make_word(input logic [7:0] data, input logic bv,
                                               input logic eom);
        sha_pkg::t_in w;
        w.data_byte      = data;
        w.byte_valid     = bv;
        w.end_of_message = eom;
        return w;
    endfunction

    // Offers one word and returns once the block has taken it. Valid stays
    // high on return, so back-to-back words never drop it for a cycle; a gap
    // lowers it first.
    task automatic send_word(input sha_pkg::t_in w);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_BURST)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (out_ready !== 1'b1);
        sha_absorb(w);
    endtask

    // Sends a message of len random bytes. The end flag rides on the last
    // byte or on a separate empty word; an empty message always uses the
    // latter. With noise_odds set, words with neither flag are mixed in.
    task automatic send_message(input int len, input bit end_on_byte, input int noise_odds,
                                output int n_words);
        int i;
        n_words = 0;
        for (i = 0; i < len; i++) begin
            if (noise_odds > 0 && $urandom_range(1, noise_odds) == 1) begin
                send_word(make_word(8'($urandom), 1'b0, 1'b0));
            end
            send_word(make_word(8'($urandom), 1'b1, end_on_byte && (i == len - 1)));
            n_words++;
        end
        if (len == 0 || !end_on_byte) begin
            send_word(make_word(8'($urandom), 1'b0, 1'b1));
            n_words++;
        end
    endtask

    // Short known messages: the empty message, a byte that carries the end
    // flag, an empty end word after bytes, ignored words between bytes, and
    // the all-zero and all-one byte values.
    task automatic test_directed();
        send_word(make_word(8'hff, 1'b0, 1'b1));
        send_word(make_word(8'h00, 1'b0, 1'b0));
        send_word(make_word(8'h61, 1'b1, 1'b0));
        send_word(make_word(8'h62, 1'b1, 1'b0));
        send_word(make_word(8'h63, 1'b1, 1'b1));
        send_word(make_word(8'h00, 1'b1, 1'b0));
        send_word(make_word(8'hff, 1'b1, 1'b0));
        send_word(make_word(8'h5a, 1'b0, 1'b1));
        send_word(make_word(8'h61, 1'b1, 1'b0));
        send_word(make_word(8'hff, 1'b0, 1'b0));
        send_word(make_word(8'h62, 1'b1, 1'b0));
        send_word(make_word(8'ha5, 1'b0, 1'b0));
        send_word(make_word(8'h00, 1'b0, 1'b1));
        send_word(make_word(8'hff, 1'b1, 1'b1));
        send_word(make_word(8'h00, 1'b1, 1'b1));
        send_word(make_word(8'h33, 1'b0, 1'b1));
    endtask

    // Lengths at the block edges: the shortest length whose padding spills
    // into a second block, and a buffer that fills exactly.
    task automatic test_block_edges();
        int lens [2] = '{56, 64};
        int i;
        int n;
        for (i = 0; i < 2; i++) begin
            send_message(lens[i], $urandom_range(0, 1), 0, n);
        end
    endtask

    // Well-formed short messages with random content and length. A share of
    // the messages has ignored words mixed in, and idling on either side
    // switches per message.
    task automatic test_random_messages();
        int total;
        int len;
        int n;
        total = 0;
        while (total < 8) begin
            len = $urandom_range(0, 6);
            tx_idle_en <= ($urandom_range(0, 3) != 0);
            rx_idle_en <= ($urandom_range(0, 3) != 0);
            send_message(len, $urandom_range(0, 1), $urandom_range(0, 1) ? 6 : 0, n);
            total += n;
        end
        rx_idle_en <= 1'b1;
    endtask

    // The receiver stops taking digest words for a long stretch while short
    // messages keep coming, so the block sits on a finished digest and has
    // to hold off the next message word.
    task automatic test_output_hold();
        int i;
        int n;
        tx_idle_en <= 1'b0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        for (i = 0; i < 3; i++) begin
            send_message($urandom_range(1, 3), $urandom_range(0, 1), 0, n);
        end
    endtask

    // The last stretch runs at full rate on both sides.
    task automatic test_no_idle();
        int total;
        int n;
        tx_idle_en <= 1'b0;
        rx_idle_en <= 1'b0;
        total = 0;
        while (total < 8) begin
            send_message($urandom_range(0, 6), $urandom_range(0, 1), 0, n);
            total += n;
        end
    endtask

    // Output side: takes digest words with random stall bursts and compares
    // each one with the oldest word still owed. Ready is a register here, so
    // its value read at the edge is the one the block saw.
    always @(posedge clk) begin : digest_check
        sha_pkg::t_out want;
        if (rst_n && out_valid === 1'b1 && in_ready) begin
            if (digest_q.size() == 0) begin
                $display("%0t: digest word with none expected, actual %h", $time, out_data);
                err_cnt++;
            end else begin
                want = digest_q.pop_front();
                if (out_data.digest_word !== want.digest_word) begin
                    $display("%0t: digest_word expected %h actual %h", $time,
                             want.digest_word, out_data.digest_word);
                    err_cnt++;
                end
                if (out_data.word_index !== want.word_index) begin
                    $display("%0t: word_index expected %0d actual %0d", $time,
                             want.word_index, out_data.word_index);
                    err_cnt++;
                end
                if (out_data.last_word !== want.last_word) begin
                    $display("%0t: last_word expected %b actual %b", $time,
                             want.last_word, out_data.last_word);
                    err_cnt++;
                end
            end
        end

        if (!rst_n || rx_hold) begin
            in_ready <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            in_ready <= 1'b0;
        end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
            rx_stall_left <= $urandom_range(1, MAX_BURST) - 1;
            in_ready <= 1'b0;
        end else begin
            in_ready <= 1'b1;
        end
    end

    initial begin
        sha_restart();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_block_edges();
        test_random_messages();
        test_output_hold();
        test_no_idle();

        in_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
